### hw/rtl/psc_pkg.sv
// Shared types and constants for the pressure sensor compensation block.
package psc_pkg;

    typedef struct packed {
        logic        cmd;
        logic [23:0] raw_reading;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] temperature_deci_c;
        logic [19:0]        pressure_pa;
        logic               status;
    } t_out;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_AC123 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC456 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B12 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MCMD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS = 3'd4;

    localparam logic       CMD_TEMP = 1'b0;
    localparam logic       CMD_PRESS = 1'b1;

    localparam logic signed [31:0] C_B6_OFS = 32'sd4000;
    localparam logic [16:0]        C_B7_SCALE = 17'd50000;
    localparam logic signed [32:0] C_P_K1 = 33'sd3038;
    localparam logic signed [32:0] C_P_K2 = -33'sd7357;
    localparam logic signed [31:0] C_P_K3 = 32'sd3791;
    localparam logic signed [31:0] C_B4_OFS = 32'sd32768;
    localparam logic signed [31:0] C_T_MAX = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN = -32'sd32768;
    localparam logic signed [31:0] C_P_MAX = 32'sd1048575;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL, S_T_X1, S_T_DEN, S_T_CHK, S_T_DIV, S_T_FIN,
        S_P_B6, S_P_SQM, S_P_SQ, S_P_X1A, S_P_X2A, S_P_B3A, S_P_B3B,
        S_P_X3, S_P_B4M, S_P_B4, S_P_B7M, S_P_B7, S_P_CHK, S_P_DIV,
        S_P_QM, S_P_Q1, S_P_Q2, S_P_Q3, S_P_FIN,
        S_OUT
    } t_state;

endpackage

### hw/rtl/psc_div.sv
// Iterative restoring divider, 32-bit unsigned, one quotient bit per cycle.
module psc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    // Shift in the next dividend bit and trial-subtract
    assign w_sh   = {r_rem[31:0], r_quo[31]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then restore or keep each step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff;
            end else begin
                r_rem <= w_sh;
            end
            r_quo <= {r_quo[30:0], ~w_diff[32]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### hw/rtl/pressure_sensor_compensation_top.sv
// Top level: integer temperature and pressure compensation sequencer.
// Results go from accept to o_out_valid through the shared registered multiplier and the
// iterative divider; a zero divisor skips the divider pass.
// One item at a time: o_in_ready is high only while the sequencer is idle.
// A new item is accepted only after the previous result is loaded into the output register.
// Synchronous active-low reset clears control, calibration registers and stored B5.
module pressure_sensor_compensation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  psc_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output psc_pkg::t_out                 o_out_data
);
    import psc_pkg::*;

    t_state r_state, n_state;

    logic [47:0] r_cal0, r_cal1;
    logic [31:0] r_cal2, r_cal3;
    logic [1:0]  r_oss;
    logic signed [31:0] r_b5;

    logic [23:0] r_raw;
    logic        r_err;
    logic        r_neg;
    logic        r_big;
    logic signed [31:0] r_x1, r_x2, r_den, r_b6, r_sq, r_tmp, r_b3, r_p;
    logic [31:0] r_b4, r_b7;
    logic [63:0] r_prod;
    t_out        r_res;
    t_out        r_out;
    logic        r_out_valid;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic        w_div_start;
    logic [31:0] w_div_a, w_div_b;
    logic        w_div_done;
    logic [31:0] w_div_q;

    // Calibration fields
    logic signed [32:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = 33'($signed(r_cal0[47:32]));
    assign w_ac2 = 33'($signed(r_cal0[31:16]));
    assign w_ac3 = 33'($signed(r_cal0[15:0]));
    assign w_ac4 = {17'b0, r_cal1[47:32]};
    assign w_ac5 = {17'b0, r_cal1[31:16]};
    assign w_ac6 = {17'b0, r_cal1[15:0]};
    assign w_b1  = 33'($signed(r_cal2[31:16]));
    assign w_b2  = 33'($signed(r_cal2[15:0]));
    assign w_mc  = 33'($signed(r_cal3[31:16]));
    assign w_md  = 33'($signed(r_cal3[15:0]));

    // Shared multiplier, registered
    assign w_prod = w_ma * w_mb;

    logic signed [31:0] w_p32;
    logic signed [31:0] w_num;
    logic [31:0]        w_up;
    logic signed [31:0] w_x2a, w_x2b, w_x2c, w_b3pre, w_b3, w_x3, w_b5, w_t, w_pf, w_dq;
    logic [15:0]        w_b7k;

    assign w_p32   = $signed(r_prod[31:0]);
    assign w_num   = {w_mc[20:0], 11'b0};
    assign w_up    = {8'b0, r_raw >> (4'd8 - {2'b0, r_oss})};
    assign w_b7k   = 16'(C_B7_SCALE >> r_oss);
    assign w_x2a   = w_p32 >>> 11;
    assign w_b3pre = ((({w_ac1[29:0], 2'b0}) + r_x1 + w_x2a) <<< r_oss) + 32'sd2;
    assign w_b3    = r_tmp[31] ? ((r_tmp + 32'sd3) >>> 2) : (r_tmp >>> 2);
    assign w_x2b   = w_p32 >>> 16;
    assign w_x3    = ((r_x1 + w_x2b + 32'sd2) >>> 2) + C_B4_OFS;
    assign w_b5    = r_x1 + r_x2;
    assign w_t     = (w_b5 + 32'sd8) >>> 4;
    assign w_x2c   = w_p32 >>> 16;
    assign w_pf    = r_p + ((r_x1 + w_x2c + C_P_K3) >>> 4);
    assign w_dq    = r_neg ? -$signed(w_div_q) : $signed(w_div_q);

    // Sequencer: next state, multiplier operands, divider start
    always_comb begin
        n_state     = r_state;
        w_ma        = '0;
        w_mb        = '0;
        w_div_start = 1'b0;
        w_div_a     = '0;
        w_div_b     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.cmd == CMD_PRESS) ? S_P_B6 : S_T_MUL;
                end
            end
            S_T_MUL: begin
                w_ma    = {17'b0, r_raw[15:0]} - w_ac6;
                w_mb    = w_ac5;
                n_state = S_T_X1;
            end
            S_T_X1:  n_state = S_T_DEN;
            S_T_DEN: n_state = S_T_CHK;
            S_T_CHK: begin
                if (r_den == '0) begin
                    n_state = S_T_FIN;
                end else begin
                    w_div_start = 1'b1;
                    w_div_a     = w_num[31] ? 32'(-w_num) : w_num;
                    w_div_b     = r_den[31] ? 32'(-r_den) : r_den;
                    n_state     = S_T_DIV;
                end
            end
            S_T_DIV: if (w_div_done) n_state = S_T_FIN;
            S_T_FIN: n_state = S_OUT;
            S_P_B6:  n_state = S_P_SQM;
            S_P_SQM: begin
                w_ma    = 33'(r_b6);
                w_mb    = 33'(r_b6);
                n_state = S_P_SQ;
            end
            S_P_SQ:  n_state = S_P_X1A;
            S_P_X1A: begin
                w_ma    = w_b2;
                w_mb    = 33'(r_sq);
                n_state = S_P_X2A;
            end
            S_P_X2A: begin
                w_ma    = w_ac2;
                w_mb    = 33'(r_b6);
                n_state = S_P_B3A;
            end
            S_P_B3A: begin
                w_ma    = w_ac3;
                w_mb    = 33'(r_b6);
                n_state = S_P_B3B;
            end
            S_P_B3B: begin
                w_ma    = w_b1;
                w_mb    = 33'(r_sq);
                n_state = S_P_X3;
            end
            S_P_X3:  n_state = S_P_B4M;
            S_P_B4M: begin
                w_ma    = w_ac4;
                w_mb    = {1'b0, r_tmp};
                n_state = S_P_B4;
            end
            S_P_B4:  n_state = S_P_B7M;
            S_P_B7M: begin
                w_ma    = {1'b0, r_tmp};
                w_mb    = {17'b0, w_b7k};
                n_state = S_P_B7;
            end
            S_P_B7:  n_state = S_P_CHK;
            S_P_CHK: begin
                if (r_b4 == '0) begin
                    n_state = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    w_div_a     = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
                    w_div_b     = r_b4;
                    n_state     = S_P_DIV;
                end
            end
            S_P_DIV: if (w_div_done) n_state = S_P_QM;
            S_P_QM: begin
                w_ma    = 33'(r_p >>> 8);
                w_mb    = 33'(r_p >>> 8);
                n_state = S_P_Q1;
            end
            S_P_Q1:  n_state = S_P_Q2;
            S_P_Q2: begin
                w_ma    = 33'(r_x1);
                w_mb    = C_P_K1;
                n_state = S_P_Q3;
            end
            S_P_Q3: begin
                w_ma    = C_P_K2;
                w_mb    = 33'(r_p);
                n_state = S_P_FIN;
            end
            S_P_FIN: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and stored B5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
            r_oss  <= '0;
            r_b5   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_AC123: r_cal0 <= i_cfg_data;
                    CFG_AC456: r_cal1 <= i_cfg_data;
                    CFG_B12:   r_cal2 <= i_cfg_data[31:0];
                    CFG_MCMD:  r_cal3 <= i_cfg_data[31:0];
                    CFG_OSS:   r_oss  <= i_cfg_data[1:0];
                    default:   ;
                endcase
            end
            if (r_state == S_T_FIN) begin
                r_b5 <= w_b5;
            end
        end
    end

    // Datapath registers, stepped by the sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[63:0];
        case (r_state)
            S_IDLE: begin
                r_raw <= i_in_data.raw_reading;
                r_err <= 1'b0;
                r_res <= '0;
            end
            S_T_X1:  r_x1 <= w_p32 >>> 15;
            S_T_DEN: r_den <= r_x1 + 32'(w_md);
            S_T_CHK: begin
                r_neg <= w_num[31] ^ r_den[31];
                if (r_den == '0) begin
                    r_x2  <= '0;
                    r_err <= 1'b1;
                end
            end
            S_T_DIV: if (w_div_done) r_x2 <= w_dq;
            S_T_FIN: begin
                r_res.kind   <= CMD_TEMP;
                r_res.status <= r_err;
                if (w_t > C_T_MAX) begin
                    r_res.temperature_deci_c <= 16'sh7fff;
                end else if (w_t < C_T_MIN) begin
                    r_res.temperature_deci_c <= 16'sh8000;
                end else begin
                    r_res.temperature_deci_c <= w_t[15:0];
                end
            end
            S_P_B6: begin
                r_b6         <= r_b5 - C_B6_OFS;
                r_res.kind   <= CMD_PRESS;
            end
            S_P_SQ:  r_sq <= w_p32 >>> 12;
            S_P_X2A: r_x1 <= w_p32 >>> 11;
            S_P_B3A: r_tmp <= w_b3pre;
            S_P_B3B: begin
                r_b3 <= w_b3;
                r_x1 <= w_p32 >>> 13;
            end
            S_P_X3:  r_tmp <= w_x3;
            S_P_B4: begin
                r_b4  <= r_prod[46:15];
                r_tmp <= w_up - r_b3;
            end
            S_P_B7:  r_b7 <= r_prod[31:0];
            S_P_CHK: begin
                r_big <= r_b7[31];
                if (r_b4 == '0) begin
                    r_res.status <= 1'b1;
                end
            end
            S_P_DIV: if (w_div_done) r_p <= r_big ? {w_div_q[30:0], 1'b0} : w_div_q;
            S_P_Q1:  r_x1 <= w_p32;
            S_P_Q3:  r_x1 <= w_p32 >>> 16;
            S_P_FIN: begin
                if (w_pf < 0) begin
                    r_res.pressure_pa <= '0;
                end else if (w_pf > C_P_MAX) begin
                    r_res.pressure_pa <= C_P_MAX[19:0];
                end else begin
                    r_res.pressure_pa <= w_pf[19:0];
                end
            end
            default: ;
        endcase
    end

    // Output register: load when free, drop on transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    psc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### hw/rtl/psc_chk.sv
// Port-level checker for the compensation block, bound to the top level.
module psc_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  psc_pkg::t_out                 o_out_data
);
    import psc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Busy after a transaction is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while previous item in progress");

    // Temperature results carry no pressure
    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == CMD_TEMP |-> o_out_data.pressure_pa == '0)
        else $error("temperature result with pressure set");

    // Pressure results carry no temperature
    a_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == CMD_PRESS |-> o_out_data.temperature_deci_c == '0)
        else $error("pressure result with temperature set");
endmodule

bind pressure_sensor_compensation_top psc_chk u_psc_chk (.*);

### tb/testbench.sv
// Self-checking testbench for the pressure sensor compensation block.
`timescale 1ns / 1ps

module testbench;
    import psc_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;

    pressure_sensor_compensation_top DUT (.*);

    // Free-running clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Calibration copy and stored B5 of the predictor
    logic [47:0] cal_ac;
    logic [47:0] cal_acu;
    logic [31:0] cal_b;
    logic [31:0] cal_m;
    logic [1:0]  oss_set;
    logic signed [31:0] b5_store;

    t_in  reading_q[$];
    t_out compensated_q[$];
    int   errors = 0;
    int   n_temp = 0;
    int   n_press = 0;
    int   n_div0 = 0;
    bit   quiet = 1'b0;
    bit   hold_off = 1'b0;

    function automatic logic signed [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensate one reading and update stored B5
    function automatic t_out compensate(t_in r);
        t_out o;
        logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, den, b5, t, b6, sq, b3, p;
        logic [31:0] up, b4, b7, pu;
        logic [63:0] w;
        o = '0;
        ac1 = sx16(cal_ac[47:32]); ac2 = sx16(cal_ac[31:16]); ac3 = sx16(cal_ac[15:0]);
        ac4 = {16'd0, cal_acu[47:32]}; ac5 = {16'd0, cal_acu[31:16]};
        ac6 = {16'd0, cal_acu[15:0]};
        b1 = sx16(cal_b[31:16]); b2 = sx16(cal_b[15:0]);
        mc = sx16(cal_m[31:16]); md = sx16(cal_m[15:0]);
        if (r.cmd == CMD_TEMP) begin
            x1 = (($signed({16'd0, r.raw_reading[15:0]}) - ac6) * ac5) >>> 15;
            den = x1 + md;
            x2 = 0;
            if (den == 0) o.status = 1'b1;
            else x2 = (mc * 32'sd2048) / den;
            b5 = x1 + x2;
            b5_store = b5;
            t = (b5 + 8) >>> 4;
            if (t > C_T_MAX) t = C_T_MAX;
            if (t < C_T_MIN) t = C_T_MIN;
            o.kind = 1'b0;
            o.temperature_deci_c = t[15:0];
        end else begin
            up = {8'd0, r.raw_reading} >> (8 - oss_set);
            b6 = b5_store - C_B6_OFS;
            sq = (b6 * b6) >>> 12;
            x1 = (b2 * sq) >>> 11;
            x2 = (ac2 * b6) >>> 11;
            x3 = x1 + x2;
            b3 = (((ac1 * 4 + x3) * (32'sd1 << oss_set)) + 2) / 4;
            x1 = (ac3 * b6) >>> 13;
            x2 = (b1 * sq) >>> 16;
            x3 = (x1 + x2 + 2) >>> 2;
            w = {32'd0, ac4} * {32'd0, x3 + C_B4_OFS};
            b4 = w[46:15];
            w = {32'd0, up - b3} * {32'd0, 32'd50000 >> oss_set};
            b7 = w[31:0];
            p = 0;
            if (b4 == 0) o.status = 1'b1;
            else begin
                if (b7 < 32'h8000_0000) pu = 32'(({32'd0, b7} * 2) / b4);
                else pu = (b7 / b4) * 2;
                p = pu;
                x1 = (p >>> 8) * (p >>> 8);
                x1 = (x1 * 32'sd3038) >>> 16;
                x2 = (-32'sd7357 * p) >>> 16;
                p = p + ((x1 + x2 + 32'sd3791) >>> 4);
                if (p < 0) p = 0;
                if (p > C_P_MAX) p = C_P_MAX;
            end
            o.kind = 1'b1;
            o.pressure_pa = p[19:0];
        end
        return o;
    endfunction

    // Input driver: offer queued readings with random idle bursts
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                compensated_q.push_back(compensate(i_in_data));
                void'(reading_q.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the transaction
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0 &&
                         !(i_in_valid && o_in_ready && reading_q.size() > 0)) begin
                in_gap <= $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (reading_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= reading_q[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver stalls
    int out_gap = 0;
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (compensated_q.size() == 0) begin
                    $error("result with nothing expected: %p", o_out_data);
                    errors++;
                end else begin
                    e = compensated_q.pop_front();
                    if (e.kind) n_press++; else n_temp++;
                    if (e.status) n_div0++;
                    if (o_out_data.kind !== e.kind) begin
                        $error("kind expected %0d actual %0d", e.kind, o_out_data.kind);
                        errors++;
                    end
                    if (o_out_data.temperature_deci_c !== e.temperature_deci_c) begin
                        $error("temperature_deci_c expected %0d actual %0d",
                               e.temperature_deci_c, o_out_data.temperature_deci_c);
                        errors++;
                    end
                    if (o_out_data.pressure_pa !== e.pressure_pa) begin
                        $error("pressure_pa expected %0d actual %0d",
                               e.pressure_pa, o_out_data.pressure_pa);
                        errors++;
                    end
                    if (o_out_data.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_out_data.status);
                        errors++;
                    end
                end
            end
            if (hold_off) i_out_ready <= 1'b0;
            else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_gap <= $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_AC123: cal_ac = val;
            CFG_AC456: cal_acu = val;
            CFG_B12:   cal_b = val[31:0];
            CFG_MCMD:  cal_m = val[31:0];
            CFG_OSS:   oss_set = val[1:0];
            default: ;
        endcase
    endtask

    // Drain everything, then let the sequencer settle
    task automatic settle();
        while (reading_q.size() > 0 || i_in_valid || compensated_q.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_cal(bit typical);
        if (typical) begin
            write_reg(CFG_AC123, {16'd408, -16'sd72, -16'sd14383});
            write_reg(CFG_AC456, {16'd32741, 16'd32757, 16'd23153});
            write_reg(CFG_B12, 48'({16'd6190, 16'd4}));
            write_reg(CFG_MCMD, 48'({-16'sd8711, 16'd2868}));
        end else begin
            write_reg(CFG_AC123, 48'({$urandom, $urandom}));
            write_reg(CFG_AC456, 48'({$urandom, $urandom}));
            write_reg(CFG_B12, 48'($urandom));
            write_reg(CFG_MCMD, 48'($urandom));
        end
    endtask

    function automatic t_in reading(logic c, logic [23:0] v);
        t_in r;
        r.cmd = c;
        r.raw_reading = v;
        return r;
    endfunction

    int phase;
    initial begin
        cal_ac = '0; cal_acu = '0; cal_b = '0; cal_m = '0; oss_set = '0; b5_store = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pressure before any temperature, both zero divisors with reset calibration
        reading_q.push_back(reading(CMD_PRESS, 24'h5D23_00));
        reading_q.push_back(reading(CMD_TEMP, 24'd0));
        settle();

        // Datasheet-like calibration, extremes of both fields, every oversampling
        load_cal(1'b1);
        for (int s = 0; s < 4; s++) begin
            write_reg(CFG_OSS, 48'(s[1:0]));
            reading_q.push_back(reading(CMD_TEMP, 24'd27898));
            reading_q.push_back(reading(CMD_PRESS, 24'h5D2300));
            reading_q.push_back(reading(CMD_PRESS, 24'hFFFFFF));
            reading_q.push_back(reading(CMD_PRESS, 24'h000000));
            settle();
        end
        reading_q.push_back(reading(CMD_TEMP, 24'hFFFFFF));
        reading_q.push_back(reading(CMD_TEMP, 24'h00FFFF));
        reading_q.push_back(reading(CMD_PRESS, 24'hAAAAAA));
        settle();
        // Temperature divisor zero: X1 is zero for raw == AC6 and MD is zero
        write_reg(CFG_MCMD, 48'({-16'sd8711, 16'd0}));
        reading_q.push_back(reading(CMD_TEMP, 24'd23153));
        reading_q.push_back(reading(CMD_PRESS, 24'h123456));
        settle();
        // Extreme calibration: all ones and zero AC4 for the pressure divisor
        write_reg(CFG_AC123, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_AC456, 48'h0000_FFFF_FFFF);
        write_reg(CFG_B12, 48'(32'hFFFF_FFFF));
        write_reg(CFG_MCMD, 48'(32'h7FFF_8000));
        reading_q.push_back(reading(CMD_TEMP, 24'h00_0001));
        reading_q.push_back(reading(CMD_PRESS, 24'hFFFFFF));
        settle();
        write_reg(CFG_OSS, 48'(2'd3));
        reading_q.push_back(reading(CMD_PRESS, 24'hFFFFFF));
        settle();

        // Random phases; most use realistic calibration, the last has no idling
        for (phase = 0; phase < 10; phase++) begin
            load_cal(phase % 3 != 2);
            write_reg(CFG_OSS, 48'($urandom_range(0, 3)));
            write_reg(3'($urandom_range(5, 7)), 48'({$urandom, $urandom}));
            quiet = (phase == 9);
            if (phase == 4) hold_off = 1'b1;
            for (int k = 0; k < 110; k++) begin
                if ($urandom_range(0, 3) == 0)
                    reading_q.push_back(reading(CMD_TEMP,
                        $urandom_range(0, 1) ? 24'($urandom)
                                             : 24'(24'd20000 + $urandom_range(0, 16000))));
                else
                    reading_q.push_back(reading(CMD_PRESS,
                        $urandom_range(0, 1) ? 24'($urandom)
                                             : 24'(24'h500000 + $urandom_range(0, 24'h200000))));
            end
            if (hold_off) begin
                // Stall the receiver long enough for the input to back up
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            settle();
        end

        $display("covered %0d temperature and %0d pressure results, %0d with divide-by-zero",
                 n_temp, n_press, n_div0);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
